@@ rtl/int8dp_pkg.sv @@
// package for the int8 dot product with norms block: word types and constants
package int8dp_pkg;

  localparam int BYTE_W    = 8;
  localparam int MAX_LANES = 8;
  localparam int ACC_W     = 28;
  localparam int NORM_W    = 27;
  localparam int PROD_W    = 16;
  localparam int SQ_W      = 15;

  // input word
  typedef struct packed {
    logic [63:0] left_bytes;
    logic [63:0] right_bytes;
    logic [3:0]  lane_count;
    logic        last_item;
  } in_word_t;

  // result word
  typedef struct packed {
    logic signed [ACC_W-1:0] inner_product;
    logic [NORM_W-1:0]       left_norm;
    logic [NORM_W-1:0]       right_norm;
  } out_word_t;

  // registered products of one lane
  typedef struct packed {
    logic signed [PROD_W-1:0] dot;
    logic [SQ_W-1:0]          left_sq;
    logic [SQ_W-1:0]          right_sq;
  } lane_prod_t;

  // control from the lane stage to the merge stage
  typedef struct packed {
    logic step;
    logic last;
  } merge_ctl_t;

endpackage

@@ rtl/int8_dot_product_with_norms.sv @@
// top level: int8 inner product and squared norms over a streamed vector pair
//
// Each input word carries up to LANES signed byte pairs (lane 0 in the low
// byte); lane_count above LANES counts as LANES and bytes of unused lanes are
// ignored. The block takes one word per clock while in_stall is low: the lane
// multipliers register their products, then the merge stage adds them into the
// three 28-bit running sums and registers the result word once the word flagged
// last reaches it, and the sums restart at zero. While a result waits on
// out_stall, words keep being accepted; in_stall rises only when another last
// word reaches the merge stage before the waiting result is taken. Sums are
// exact up to 8191 elements per vector and wrap modulo 2^28 beyond that, each
// norm being the low 27 bits of its sum.
module int8_dot_product_with_norms #(
  parameter int LANES = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  int8dp_pkg::in_word_t  in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output int8dp_pkg::out_word_t out_data
);

  localparam logic [3:0] LANE_LIMIT = 4'(LANES);

  logic                               s1_valid_r;
  logic                               s1_last_r;
  logic                               s1_adv;
  logic                               load;
  logic [3:0]                         lane_cnt;
  logic [LANES-1:0]                   lane_on;
  int8dp_pkg::lane_prod_t [LANES-1:0] prods;
  int8dp_pkg::merge_ctl_t             ctl;

  // stage one moves on unless it holds a last word and the result is still held
  assign s1_adv   = !(s1_valid_r && s1_last_r && out_valid && out_stall);
  assign in_stall = !s1_adv;
  assign load     = in_valid && s1_adv;

  // clamp the lane count and mark active lanes
  always_comb begin
    lane_cnt = (in_data.lane_count > LANE_LIMIT) ? LANE_LIMIT : in_data.lane_count;
    for (int i = 0; i < LANES; i++) begin
      lane_on[i] = 4'(i) < lane_cnt;
    end
  end

  // stage one control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s1_last_r  <= 1'b0;
    end else if (s1_adv) begin
      s1_valid_r <= in_valid;
      s1_last_r  <= in_data.last_item;
    end
  end

  // lane multipliers
  for (genvar g = 0; g < LANES; g++) begin : g_lane
    int8dp_lane u_lane (
      .clk     (clk),
      .load    (load),
      .lane_on (lane_on[g]),
      .left    (in_data.left_bytes[g*8 +: 8]),
      .right   (in_data.right_bytes[g*8 +: 8]),
      .prod    (prods[g])
    );
  end

  assign ctl.step = s1_valid_r && s1_adv;
  assign ctl.last = s1_last_r;

  // merge and accumulate
  int8dp_merge #(
    .LANES (LANES)
  ) u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .prods     (prods),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

@@ rtl/int8dp_lane.sv @@
// one lane: signed 8-bit product and both squares, registered
module int8dp_lane (
  input  logic                    clk,
  input  logic                    load,
  input  logic                    lane_on,
  input  logic [7:0]              left,
  input  logic [7:0]              right,
  output int8dp_pkg::lane_prod_t  prod
);

  logic signed [15:0]     left_ext;
  logic signed [15:0]     right_ext;
  logic signed [15:0]     dot_full;
  logic signed [15:0]     lsq_full;
  logic signed [15:0]     rsq_full;
  int8dp_pkg::lane_prod_t prod_r;
  int8dp_pkg::lane_prod_t prod_nxt;

  // sign extend and multiply, -128 * -128 fits exactly
  always_comb begin
    left_ext  = {{8{left[7]}}, left};
    right_ext = {{8{right[7]}}, right};
    dot_full  = left_ext * right_ext;
    lsq_full  = left_ext * left_ext;
    rsq_full  = right_ext * right_ext;
  end

  // invalid lanes contribute zero
  always_comb begin
    if (lane_on) begin
      prod_nxt.dot      = dot_full;
      prod_nxt.left_sq  = lsq_full[14:0];
      prod_nxt.right_sq = rsq_full[14:0];
    end else begin
      prod_nxt = '0;
    end
  end

  // product register
  always_ff @(posedge clk) begin
    if (load) begin
      prod_r <= prod_nxt;
    end
  end

  assign prod = prod_r;

endmodule

@@ rtl/int8dp_merge.sv @@
// merge stage: sums lane products, keeps the running sums, holds the result word
module int8dp_merge #(
  parameter int LANES = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  int8dp_pkg::merge_ctl_t              ctl,
  input  int8dp_pkg::lane_prod_t [LANES-1:0]  prods,
  input  logic                                out_stall,
  output logic                                out_valid,
  output int8dp_pkg::out_word_t               out_data
);

  logic signed [18:0]                       dot_sum;
  logic [17:0]                              lsq_sum;
  logic [17:0]                              rsq_sum;
  logic signed [int8dp_pkg::ACC_W-1:0]      dot_acc_r;
  logic signed [int8dp_pkg::ACC_W-1:0]      dot_acc_nxt;
  logic [int8dp_pkg::ACC_W-1:0]             left_acc_r;
  logic [int8dp_pkg::ACC_W-1:0]             left_acc_nxt;
  logic [int8dp_pkg::ACC_W-1:0]             right_acc_r;
  logic [int8dp_pkg::ACC_W-1:0]             right_acc_nxt;
  logic                                     out_valid_r;
  int8dp_pkg::out_word_t                    out_data_r;

  // sum across lanes
  always_comb begin
    dot_sum = '0;
    lsq_sum = '0;
    rsq_sum = '0;
    for (int i = 0; i < LANES; i++) begin
      dot_sum = dot_sum + 19'(prods[i].dot);
      lsq_sum = lsq_sum + 18'(prods[i].left_sq);
      rsq_sum = rsq_sum + 18'(prods[i].right_sq);
    end
  end

  // running sums with the current item folded in, wrapping at 28 bits
  always_comb begin
    dot_acc_nxt   = dot_acc_r + 28'(dot_sum);
    left_acc_nxt  = left_acc_r + 28'(lsq_sum);
    right_acc_nxt = right_acc_r + 28'(rsq_sum);
  end

  // accumulators, cleared after a last item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dot_acc_r   <= '0;
      left_acc_r  <= '0;
      right_acc_r <= '0;
    end else if (ctl.step) begin
      if (ctl.last) begin
        dot_acc_r   <= '0;
        left_acc_r  <= '0;
        right_acc_r <= '0;
      end else begin
        dot_acc_r   <= dot_acc_nxt;
        left_acc_r  <= left_acc_nxt;
        right_acc_r <= right_acc_nxt;
      end
    end
  end

  // result valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.step && ctl.last) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (ctl.step && ctl.last) begin
      out_data_r.inner_product <= dot_acc_nxt;
      out_data_r.left_norm     <= left_acc_nxt[int8dp_pkg::NORM_W-1:0];
      out_data_r.right_norm    <= right_acc_nxt[int8dp_pkg::NORM_W-1:0];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ sim/tb_int8_dot_product_with_norms.sv @@
// testbench for the int8 dot product with squared norms block
`timescale 1ns / 100ps

module tb_int8_dot_product_with_norms;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  int8dp_pkg::in_word_t  in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  int8dp_pkg::out_word_t out_data;

  // words waiting to be sent and sum words waiting to come back
  int8dp_pkg::in_word_t  pending_words[$];
  int8dp_pkg::out_word_t sums_due[$];

  // running sums as the block should hold them
  logic [int8dp_pkg::ACC_W-1:0] dot_run = '0;
  logic [int8dp_pkg::ACC_W-1:0] left_run = '0;
  logic [int8dp_pkg::ACC_W-1:0] right_run = '0;

  int   errors = 0;
  int   words_taken = 0;
  int   results_seen = 0;
  int   send_gap = 0;
  int   send_pace = 0;
  int   recv_wait = 0;
  int   recv_pace = 0;
  logic hold_off = 1'b0;

  int8_dot_product_with_norms dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  // 10 ns clock
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    errors++;
  endtask

  // wait drawn per item: none, an occasional random wait, or a random wait every time
  function automatic int draw_wait(input int pace);
    if (pace == 0) return 0;
    if (pace == 1) return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 14) : 0;
    return $urandom_range(0, 14);
  endfunction

  // add one accepted word into the running sums, queue the sums on a last word
  task automatic fold_word(input int8dp_pkg::in_word_t w);
    int n;
    logic signed [7:0]                    a;
    logic signed [7:0]                    b;
    logic signed [int8dp_pkg::ACC_W-1:0]  pd;
    logic signed [int8dp_pkg::ACC_W-1:0]  pl;
    logic signed [int8dp_pkg::ACC_W-1:0]  pr;
    int8dp_pkg::out_word_t                sums;
    n = (w.lane_count > int8dp_pkg::MAX_LANES) ? int8dp_pkg::MAX_LANES : w.lane_count;
    for (int i = 0; i < n; i++) begin
      a = w.left_bytes[8*i +: 8];
      b = w.right_bytes[8*i +: 8];
      pd = a * b;
      pl = a * a;
      pr = b * b;
      dot_run   = dot_run + pd;
      left_run  = left_run + pl;
      right_run = right_run + pr;
    end
    if (w.last_item) begin
      sums.inner_product = dot_run;
      sums.left_norm     = left_run[int8dp_pkg::NORM_W-1:0];
      sums.right_norm    = right_run[int8dp_pkg::NORM_W-1:0];
      sums_due.push_back(sums);
      dot_run   = '0;
      left_run  = '0;
      right_run = '0;
    end
  endtask

  function automatic logic [63:0] rand_lanes(input int style);
    logic [63:0] v;
    v = {$urandom, $urandom};
    if (style == 1) begin
      // mostly the corner bytes
      for (int i = 0; i < 8; i++) begin
        case ($urandom_range(0, 5))
          0: v[8*i +: 8] = 8'h80;
          1: v[8*i +: 8] = 8'h7F;
          2: v[8*i +: 8] = 8'h00;
          3: v[8*i +: 8] = 8'hFF;
          4: v[8*i +: 8] = 8'h81;
          default: ;
        endcase
      end
    end
    return v;
  endfunction

  task automatic push_word(input logic [63:0] l, input logic [63:0] r,
                           input logic [3:0] cnt, input logic last);
    int8dp_pkg::in_word_t w;
    w.left_bytes  = l;
    w.right_bytes = r;
    w.lane_count  = cnt;
    w.last_item   = last;
    pending_words.push_back(w);
  endtask

  // input driver: holds a word until taken, then waits its drawn gap
  always @(posedge clk) begin : driver
    logic held;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      held = in_valid;
      if (in_valid && !in_stall) begin
        fold_word(in_data);
        words_taken++;
        held = 1'b0;
        if (words_taken % 50 == 0) send_pace = $urandom_range(0, 2);
        send_gap = draw_wait(send_pace);
      end
      if (!held) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_words.size() > 0) begin
          in_data  <= pending_words.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stall
  always @(posedge clk) begin : monitor
    int8dp_pkg::out_word_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (sums_due.size() == 0) begin
          report_mismatch("result word with nothing expected");
        end else begin
          want = sums_due.pop_front();
          if (out_data.inner_product !== want.inner_product)
            report_mismatch($sformatf("inner_product got %0d want %0d",
                                      out_data.inner_product, want.inner_product));
          if (out_data.left_norm !== want.left_norm)
            report_mismatch($sformatf("left_norm got %0d want %0d",
                                      out_data.left_norm, want.left_norm));
          if (out_data.right_norm !== want.right_norm)
            report_mismatch($sformatf("right_norm got %0d want %0d",
                                      out_data.right_norm, want.right_norm));
        end
        if (results_seen % 16 == 0) recv_pace = $urandom_range(0, 2);
        recv_wait = draw_wait(recv_pace);
      end
      if (recv_wait > 0) begin
        recv_wait--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= hold_off;
      end
    end
  end

  // one long receiver hold-off so the block backs up into its input
  initial begin : long_hold
    wait (results_seen >= 20);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (400) @(posedge clk);
    hold_off <= 1'b0;
  end

  // stimulus and end of run
  initial begin : stimulus
    int  len;
    int  style;
    bit  long_done;
    long_done = 1'b0;

    // directed: corner bytes and lane counts
    push_word({8{8'h80}}, {8{8'h80}}, 4'd8, 1'b1);   // -128 times -128 on every lane
    push_word({8{8'h7F}}, {8{8'h80}}, 4'd8, 1'b1);
    push_word({8{8'h7F}}, {8{8'h7F}}, 4'd8, 1'b1);
    push_word({8{8'hFF}}, {8{8'h01}}, 4'd8, 1'b1);
    push_word('0, '0, 4'd0, 1'b1);                   // empty last with nothing summed
    push_word({8{8'h80}}, {8{8'h7F}}, 4'd15, 1'b0);  // count above lane total
    push_word({8{8'h55}}, {8{8'hAA}}, 4'd0, 1'b1);   // empty last flushes sums
    push_word(64'h8080_8080_8003_02FF, 64'h7F7F_7F7F_7F81_8001, 4'd3, 1'b1);
    push_word(rand_lanes(0), rand_lanes(0), 4'd9, 1'b1);
    push_word(rand_lanes(0), rand_lanes(0), 4'd1, 1'b1);
    push_word(rand_lanes(1), rand_lanes(1), 4'd8, 1'b0);  // multi-word vector
    push_word(rand_lanes(1), rand_lanes(1), 4'd5, 1'b0);
    push_word(rand_lanes(1), rand_lanes(1), 4'd2, 1'b0);
    push_word(rand_lanes(1), rand_lanes(1), 4'd8, 1'b1);
    push_word('0, '0, 4'd8, 1'b0);
    push_word({8{8'h80}}, {8{8'h80}}, 4'd7, 1'b1);
    push_word(rand_lanes(0), rand_lanes(0), 4'd4, 1'b1);  // back-to-back lasts
    push_word(rand_lanes(0), rand_lanes(0), 4'd6, 1'b1);
    push_word(rand_lanes(0), rand_lanes(0), 4'd12, 1'b1);
    push_word('1, '1, 4'd8, 1'b1);

    // random vector pairs, one of them long enough to pass the exact range
    while (pending_words.size() < 1950) begin
      if (!long_done && pending_words.size() > 900) begin
        for (int j = 0; j < 1100; j++)
          push_word({8{8'h80}}, {8{8'h80}}, 4'd8, j == 1099);
        long_done = 1'b1;
      end else begin
        len = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
        style = $urandom_range(0, 1);
        for (int j = 0; j < len; j++)
          push_word(rand_lanes(style), rand_lanes(style),
                    ($urandom_range(0, 3) != 0) ? 4'd8 : 4'($urandom_range(0, 15)),
                    j == len - 1);
      end
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    wait (pending_words.size() == 0 && !in_valid);
    wait (sums_due.size() == 0);
    repeat (20) @(posedge clk);
    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  // watchdog
  initial begin : watchdog
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
